// ===== design/cbbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Changed-block bitmap to ranges: shared definitions
// Field widths, register indexes, payload structs and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package cbbr_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int IN_WORD_W     = 64;
	localparam int ID_W          = 48;
	localparam int LEN_W         = ID_W + 1;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = LEN_W;

	// One past the largest block id that fits, 2^ID_W.
	localparam logic [LEN_W:0] ID_LIMIT = {2'b01, {ID_W{1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_START_BLOCK = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = CFG_IDX_W'(2);

	localparam logic MODE_LIST  = 1'b0;
	localparam logic MODE_RANGE = 1'b1;

	typedef struct packed {
		logic [IN_WORD_W-1:0] bitmap_word;
		logic                 flush;
	} cbbr_in_t;

	typedef struct packed {
		logic [ID_W-1:0]  record_start;
		logic [LEN_W-1:0] record_length;
		logic             last_of_item;
	} cbbr_out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic close;
		logic finish;
	} cbbr_cmd_t;

	typedef struct packed {
		logic in_range;
		logic evt;
		logic pend_valid;
		logic out_free;
		logic run_open;
		logic cnt_last;
		logic flush;
	} cbbr_sts_t;

endpackage
`default_nettype wire

// ===== design/cbbr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Changed-block bitmap to ranges: controller
// Sequences one bitmap word at a time through walk, close and final-record
// phases, holding the walk whenever a record cannot be handed on.
// ----------------------------------------------------------------------------
module cbbr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bitmap_valid,
	output logic                bitmap_stall,
	input  cbbr_pkg::cbbr_sts_t sts,
	output cbbr_pkg::cbbr_cmd_t cmd
);
	import cbbr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_CLOSE,
		ST_LAST
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;
	logic   hold;

	assign bitmap_stall = stall_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		// A new record may only displace the pending one if the output is free.
		hold    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = bitmap_valid & ~stall_q;
				if (cmd.load) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				hold     = sts.evt & sts.pend_valid & ~sts.out_free;
				cmd.step = sts.in_range & ~hold;
				if (!sts.in_range || (cmd.step && sts.cnt_last)) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				hold      = sts.run_open & sts.pend_valid & ~sts.out_free;
				cmd.close = sts.flush & ~hold;
				if (!sts.flush || cmd.close) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				cmd.finish = sts.pend_valid & sts.out_free;
				if (!sts.pend_valid || cmd.finish) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != ST_IDLE);
		end
	end

endmodule
`default_nettype wire

// ===== design/cbbr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Changed-block bitmap to ranges: datapath
// Configuration registers, stream position, open run, a one-record pending
// buffer and the output register. One bitmap bit is examined per step.
// ----------------------------------------------------------------------------
module cbbr_dp #(
	parameter int WORD_BITS = cbbr_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cbbr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbbr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  cbbr_pkg::cbbr_in_t               bitmap,
	input  cbbr_pkg::cbbr_cmd_t              cmd,
	output cbbr_pkg::cbbr_sts_t              sts,
	output logic                             record_valid,
	input  logic                             record_stall,
	output cbbr_pkg::cbbr_out_t              record
);
	import cbbr_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);

	logic [ID_W-1:0]      start_q;
	logic [LEN_W-1:0]     count_q;
	logic                 mode_q;
	logic [LEN_W-1:0]     end_q;
	logic [LEN_W-1:0]     next_q;
	logic [ID_W-1:0]      run_first_q;
	logic [LEN_W-1:0]     run_len_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 flush_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 pend_valid_q;
	logic [ID_W-1:0]      pend_start_q;
	logic [LEN_W-1:0]     pend_len_q;
	logic                 out_valid_q;
	cbbr_out_t            out_q;

	logic                 cur_set;
	logic                 in_range;
	logic                 run_open;
	logic                 evt;
	logic                 out_free;
	logic                 new_rec;
	logic                 push;
	logic [ID_W-1:0]      rec_start;
	logic [LEN_W-1:0]     rec_len;
	logic [LEN_W:0]       end_sum;
	logic [LEN_W-1:0]     end_cap;

	assign cur_set  = word_q[0];
	assign in_range = next_q < end_q;
	assign run_open = run_len_q != '0;
	assign out_free = ~out_valid_q | ~record_stall;

	// A set bit yields a single-block record in list mode; a clear bit closes
	// any open run whatever the mode.
	assign evt = in_range & (cur_set ? (mode_q == MODE_LIST) : run_open);

	always_comb begin
		if (cmd.step && cur_set) begin
			rec_start = next_q[ID_W-1:0];
			rec_len   = LEN_W'(1);
		end else begin
			rec_start = run_first_q;
			rec_len   = run_len_q;
		end
	end

	assign new_rec = (cmd.step & evt) | (cmd.close & run_open);
	assign push    = (new_rec & pend_valid_q) | cmd.finish;

	// The stream end is capped at the first id that does not fit.
	assign end_sum = {1'b0, 1'b0, start_q} + {1'b0, count_q};
	assign end_cap = (end_sum > ID_LIMIT) ? ID_LIMIT[LEN_W-1:0] : end_sum[LEN_W-1:0];

	always_comb begin
		sts            = '0;
		sts.in_range   = in_range;
		sts.evt        = evt;
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
		sts.run_open   = run_open;
		sts.cnt_last   = cnt_q == CNT_W'(WORD_BITS - 1);
		sts.flush      = flush_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			count_q      <= '0;
			mode_q       <= MODE_LIST;
			next_q       <= '0;
			run_first_q  <= '0;
			run_len_q    <= '0;
			flush_q      <= 1'b0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_BLOCK: begin
						start_q     <= cfg_data[ID_W-1:0];
						next_q      <= {1'b0, cfg_data[ID_W-1:0]};
						run_first_q <= '0;
						run_len_q   <= '0;
					end
					REG_BLOCK_COUNT: begin
						count_q <= cfg_data[LEN_W-1:0];
					end
					REG_OUTPUT_MODE: begin
						mode_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end

			if (cmd.load) begin
				flush_q <= bitmap.flush;
				cnt_q   <= '0;
			end

			if (cmd.step) begin
				cnt_q  <= cnt_q + CNT_W'(1);
				next_q <= next_q + LEN_W'(1);
				if (cur_set && mode_q == MODE_RANGE) begin
					if (!run_open) begin
						run_first_q <= next_q[ID_W-1:0];
					end
					run_len_q <= run_len_q + LEN_W'(1);
				end else if (!cur_set) begin
					run_len_q <= '0;
				end
			end

			if (cmd.close) begin
				run_first_q <= '0;
				run_len_q   <= '0;
				next_q      <= {1'b0, start_q};
			end

			if (new_rec) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!record_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= bitmap.bitmap_word[WORD_BITS-1:0];
			end_q  <= end_cap;
		end else if (cmd.step) begin
			word_q <= word_q >> 1;
		end
		if (new_rec) begin
			pend_start_q <= rec_start;
			pend_len_q   <= rec_len;
		end
		if (push) begin
			out_q.record_start  <= pend_start_q;
			out_q.record_length <= pend_len_q;
			out_q.last_of_item  <= cmd.finish;
		end
	end

	assign record_valid = out_valid_q;
	assign record       = out_q;

endmodule
`default_nettype wire

// ===== design/changed_block_bitmap_to_ranges.sv =====
// The walk looks at one bitmap bit per cycle, while the output does not stall, until
// the word or the reporting window ends; then a flushed run is closed and the final
// record is handed on. A stalled output holds the walk for as long as it lasts.
// A new word is taken only once the previous word, with its final record, is done.
// Reset clears control and configuration registers (list mode, empty window); idle.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Changed-block bitmap to ranges: top level
// Turns a stream of changed-block bitmap words into block or range records.
// ----------------------------------------------------------------------------
module changed_block_bitmap_to_ranges #(
	parameter int WORD_BITS = cbbr_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cbbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbbr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            bitmap_valid,
	output logic                            bitmap_stall,
	input  cbbr_pkg::cbbr_in_t              bitmap,
	output logic                            record_valid,
	input  logic                            record_stall,
	output cbbr_pkg::cbbr_out_t             record
);
	import cbbr_pkg::*;

	cbbr_cmd_t cmd;
	cbbr_sts_t sts;

	cbbr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.bitmap_valid (bitmap_valid),
		.bitmap_stall (bitmap_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	cbbr_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.bitmap       (bitmap),
		.cmd          (cmd),
		.sts          (sts),
		.record_valid (record_valid),
		.record_stall (record_stall),
		.record       (record)
	);

endmodule
`default_nettype wire

// ===== design/cbbr_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Changed-block bitmap to ranges: port checker
// Watches the top level's channels and flags ordering or payload slips.
// ----------------------------------------------------------------------------
module cbbr_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                bitmap_valid,
	input logic                bitmap_stall,
	input logic                record_valid,
	input logic                record_stall,
	input cbbr_pkg::cbbr_out_t record
);
	import cbbr_pkg::*;

	// A record offered under stall stays offered and unchanged.
	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_stall |=> record_valid && $stable(record))
		else $error("record changed or dropped while stalled");

	// Only one word is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		bitmap_valid && !bitmap_stall |=> bitmap_stall)
		else $error("second word taken while one is in work");

	// Every record covers at least one block.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid |-> record.record_length != '0)
		else $error("record with zero length");

	// After a record that is not the last of its word, either the word is still
	// in work or its final record is already on offer.
	a_last_before_idle: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && !record_stall && !record.last_of_item |=>
			bitmap_stall || record_valid)
		else $error("word finished without a final record");

endmodule

bind changed_block_bitmap_to_ranges cbbr_chk u_cbbr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.bitmap_valid (bitmap_valid),
	.bitmap_stall (bitmap_stall),
	.record_valid (record_valid),
	.record_stall (record_stall),
	.record       (record)
);
`default_nettype wire
